@@ sv/psob_pkg.sv @@
// ----------------------------------------------------------------------------
// Premultiplied source-over blend: shared package
// Widths, register indexes and selection codes used by the blend pipeline.
// ----------------------------------------------------------------------------
package psob_pkg;

  localparam int PIX_W   = 32;
  localparam int CHAN_W  = 8;
  localparam int ALPHA_W = 9;
  localparam int NUM_CHAN = PIX_W / CHAN_W;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;
  localparam logic [CHAN_W-1:0]  BYTE_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0]  ROUND_HALF = 8'h80;

  // configuration register indexes
  localparam logic REG_GLOBAL_ALPHA = 1'b0;
  localparam logic REG_OPAQUE_MODE  = 1'b1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // what the last stage returns
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BLEND = 2'd0;
  localparam kind_t KIND_SRC   = 2'd1;
  localparam kind_t KIND_DST   = 2'd2;

endpackage

@@ sv/premultiplied_source_over_blend.sv @@
// ----------------------------------------------------------------------------
// Premultiplied source-over blend
// Four-stage pipeline blending one premultiplied ARGB32 pixel pair a cycle when not stalled.
// ----------------------------------------------------------------------------
// Blends a premultiplied ARGB32 source word over a destination word, giving
// src + dst * (255 - src_alpha) / 255 per channel after the source has been
// scaled by a global alpha of 0..256 (values above 256 act as 256). At 256
// the source is used as it stands: an opaque source (or any source when the
// opaque source mode is set) is copied, an all-zero source leaves the
// destination unchanged. At 0 the destination passes through. The block
// takes one word every clock while pixel_stall is low and passes it through
// decode, source scale, destination scale and final add, one register stage
// each, before presenting the result on the output. The two scale stages
// are each built around one bank of four 8x8 byte multipliers and the final
// add stage around the 32-bit add. Every stage holds its own valid bit,
// so a stall on the result side only backs up as far as the first empty
// stage. Write the configuration registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
module premultiplied_source_over_blend (
  input  logic                            clk,
  input  logic                            rst,

  // configuration write port
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [psob_pkg::ALPHA_W-1:0]    cfg_data,

  // pixel pair words in
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  psob_pkg::pixel_t                source_pixel,
  input  psob_pkg::pixel_t                destination_pixel,

  // blended words out
  output logic                            blend_valid,
  input  logic                            blend_stall,
  output psob_pkg::pixel_t                blended_pixel
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [psob_pkg::ALPHA_W-1:0] global_alpha;
  logic                         opaque_source_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_alpha       <= psob_pkg::ALPHA_FULL;
      opaque_source_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psob_pkg::REG_GLOBAL_ALPHA: global_alpha       <= cfg_data;
        psob_pkg::REG_OPAQUE_MODE:  opaque_source_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor moves on
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || !blend_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pixel_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pixel_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode the case and work out the source scale factor
  // --------------------------------------------------------------------------
  logic [psob_pkg::ALPHA_W-1:0]     ga_sat;
  logic [2*psob_pkg::CHAN_W:0]      ga_scaled;
  psob_pkg::kind_t                  kind_next;
  logic                             scale_next;

  assign ga_sat = (global_alpha > psob_pkg::ALPHA_FULL) ? psob_pkg::ALPHA_FULL
                                                         : global_alpha;
  // (ga * 255) >> 8; only taken for ga below 256, so bits 15..8 hold it
  assign ga_scaled = (2*psob_pkg::CHAN_W+1)'(ga_sat)
                   * (2*psob_pkg::CHAN_W+1)'(psob_pkg::BYTE_MAX);

  always_comb begin
    kind_next  = psob_pkg::KIND_BLEND;
    scale_next = 1'b0;
    if (ga_sat == psob_pkg::ALPHA_FULL) begin
      if (opaque_source_mode ||
          source_pixel[psob_pkg::PIX_W-1 -: psob_pkg::CHAN_W] == psob_pkg::BYTE_MAX) begin
        kind_next = psob_pkg::KIND_SRC;
      end else if (source_pixel == '0) begin
        kind_next = psob_pkg::KIND_DST;
      end
    end else if (ga_sat == '0) begin
      kind_next = psob_pkg::KIND_DST;
    end else begin
      scale_next = 1'b1;
    end
  end

  psob_pkg::pixel_t s1_src, s1_dst;
  psob_pkg::kind_t  s1_kind;
  logic             s1_scale;
  psob_pkg::chan_t  s1_ca;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_src   <= source_pixel;
      s1_dst   <= destination_pixel;
      s1_kind  <= kind_next;
      s1_scale <= scale_next;
      s1_ca    <= ga_scaled[2*psob_pkg::CHAN_W-1:psob_pkg::CHAN_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale the source by the global alpha, or pass it as it is
  // --------------------------------------------------------------------------
  psob_pkg::pixel_t src_scaled;

  psob_pix_mul u_src_mul (
    .pixel   (s1_src),
    .alpha   (s1_ca),
    .product (src_scaled)
  );

  psob_pkg::pixel_t s2_src, s2_dst;
  psob_pkg::kind_t  s2_kind;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_src  <= s1_scale ? src_scaled : s1_src;
      s2_dst  <= s1_dst;
      s2_kind <= s1_kind;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale the destination by the inverse source alpha
  // --------------------------------------------------------------------------
  psob_pkg::chan_t  inv_alpha;
  psob_pkg::pixel_t dst_scaled;

  assign inv_alpha = psob_pkg::BYTE_MAX - s2_src[psob_pkg::PIX_W-1 -: psob_pkg::CHAN_W];

  psob_pix_mul u_dst_mul (
    .pixel   (s2_dst),
    .alpha   (inv_alpha),
    .product (dst_scaled)
  );

  psob_pkg::pixel_t s3_src, s3_dst, s3_dst_scaled;
  psob_pkg::kind_t  s3_kind;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_src        <= s2_src;
      s3_dst        <= s2_dst;
      s3_dst_scaled <= dst_scaled;
      s3_kind       <= s2_kind;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: final add (one 32-bit add, carries cross channels) and select
  // --------------------------------------------------------------------------
  psob_pkg::pixel_t result_next;

  always_comb begin
    case (s3_kind)
      psob_pkg::KIND_SRC: result_next = s3_src;
      psob_pkg::KIND_DST: result_next = s3_dst;
      default:            result_next = s3_src + s3_dst_scaled;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      blended_pixel <= result_next;
    end
  end

  assign blend_valid = v4;

endmodule

@@ sv/psob_pix_mul.sv @@
// ----------------------------------------------------------------------------
// Premultiplied source-over blend: pixel by alpha multiply
// Scales each byte lane of a pixel by an 8-bit alpha with rounding:
// t = c * a, result = (t + (t >> 8) + 0x80) >> 8.
// ----------------------------------------------------------------------------
module psob_pix_mul (
  input  psob_pkg::pixel_t pixel,
  input  psob_pkg::chan_t  alpha,
  output psob_pkg::pixel_t product
);

  genvar lane;
  generate
    for (lane = 0; lane < psob_pkg::NUM_CHAN; lane++) begin : g_lane
      logic [2*psob_pkg::CHAN_W-1:0] t;
      logic [2*psob_pkg::CHAN_W:0]   rounded;

      assign t = pixel[lane*psob_pkg::CHAN_W +: psob_pkg::CHAN_W] * alpha;
      // fold the high byte back in so that 255 * c / 255 gives c exactly
      assign rounded = (2*psob_pkg::CHAN_W+1)'(t)
                     + (2*psob_pkg::CHAN_W+1)'(t[2*psob_pkg::CHAN_W-1:psob_pkg::CHAN_W])
                     + (2*psob_pkg::CHAN_W+1)'(psob_pkg::ROUND_HALF);
      assign product[lane*psob_pkg::CHAN_W +: psob_pkg::CHAN_W] =
        rounded[2*psob_pkg::CHAN_W-1:psob_pkg::CHAN_W];
    end
  endgenerate

endmodule
